// File: rtl/core/igp_pkg.sv
package igp_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam int DATA_W   = 32;
	localparam int WEIGHT_W = 17;
	localparam int SIZE_W   = 8;
	localparam int CMD_W    = 2;
	localparam int COORD_W  = 7;
	localparam int REG_IDX_W = 2;

	localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PROPAGATE = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DECAY       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MOMENTUM    = 2'd3;

	// Tag that travels with one grid read through the neighbor pipeline.
	typedef struct packed {
		logic valid;
		logic use_nb;
		logic center;
	} nb_tag_t;

	// Strobes from the sequencer to the cell arithmetic.
	typedef struct packed {
		logic start;
		logic blend;
	} cu_ctl_t;

endpackage

// File: rtl/core/igp_if.sv
interface igp_req_if;
	logic                           valid;
	logic                           ready;
	logic [igp_pkg::CMD_W-1:0]      cmd;
	logic [igp_pkg::COORD_W-1:0]    cell_x;
	logic [igp_pkg::COORD_W-1:0]    cell_y;
	logic signed [igp_pkg::DATA_W-1:0] cell_value;

	modport source (output valid, cmd, cell_x, cell_y, cell_value, input ready);
	modport sink   (input valid, cmd, cell_x, cell_y, cell_value, output ready);
endinterface

interface igp_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [igp_pkg::DATA_W-1:0] read_value;
	logic                              sweep_done;

	modport source (output valid, read_value, sweep_done, input ready);
	modport sink   (input valid, read_value, sweep_done, output ready);
endinterface

interface igp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [igp_pkg::REG_IDX_W-1:0]    index;
	logic [igp_pkg::WEIGHT_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/igp_ram.sv
module igp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/igp_cell_unit.sv
module igp_cell_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  igp_pkg::cu_ctl_t                      ctl,
	input  igp_pkg::nb_tag_t                      tag_s1,
	input  logic signed [igp_pkg::DATA_W-1:0]     rdata,
	input  logic [igp_pkg::WEIGHT_W-1:0]          decay,
	input  logic [igp_pkg::WEIGHT_W-1:0]          mom,
	output logic signed [igp_pkg::DATA_W-1:0]     result
);

	localparam int DW = igp_pkg::DATA_W;

	igp_pkg::nb_tag_t    tag_s2;
	logic signed [50:0]  prod_s2;
	logic signed [32:0]  term;
	logic signed [32:0]  hi_q;
	logic signed [32:0]  lo_q;
	logic signed [DW-1:0] old_q;
	logic signed [34:0]  diff;
	logic signed [52:0]  blend_q;
	logic signed [37:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// Neighbor scale: value times decay, floored by the arithmetic shift.
	always_ff @(posedge clk) begin
		prod_s2 <= 51'(signed'({rdata[DW-1], rdata})) * 51'(signed'({1'b0, decay}));
		if (tag_s1.valid && tag_s1.center) begin
			old_q <= rdata;
		end
	end

	assign term = 33'(prod_s2 >>> 16);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (tag_s2.valid && tag_s2.use_nb) begin
			if (term > hi_q) begin
				hi_q <= term;
			end
			if (term < lo_q) begin
				lo_q <= term;
			end
		end
		if (ctl.blend) begin
			blend_q <= 53'(diff) * 53'(signed'({1'b0, mom}));
		end
	end

	assign diff = 35'(hi_q) + 35'(lo_q) - 35'(old_q);
	assign sum  = 38'(old_q) + 38'(blend_q >>> 16);

	always_comb begin
		if (sum > 38'sd2147483647) begin
			result = 32'sh7fffffff;
		end else if (sum < -38'sd2147483648) begin
			result = 32'sh80000000;
		end else begin
			result = sum[DW-1:0];
		end
	end

endmodule

// File: rtl/core/influence_grid_propagator.sv
// Channel | Role   | Payload
// req     | sink   | cmd, cell_x, cell_y, cell_value
// rsp     | source | read_value, sweep_done
// cfg     | sink   | index, data (register write)
//
// A write request completes in the idle state; a read request passes through a
// result state, set by the registered read port of the grid memory. A propagate
// request visits each active cell in both sweeps (nine reads on the single read
// port, a pipeline wait, a blend multiply and a write), then a done state.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT cells,
// one per cycle; no request is taken during it, configuration writes are.
// A result waits in the output register; a stalled response channel holds only
// the next read or propagate completion, not write requests.
module influence_grid_propagator #(
	parameter int MAX_WIDTH  = igp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = igp_pkg::DEF_MAX_HEIGHT
) (
	input  logic   clk,
	input  logic   arst_n,
	igp_req_if.sink   req,
	igp_rsp_if.source rsp,
	igp_cfg_if.sink   cfg
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DW    = igp_pkg::DATA_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RRES  = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_BL    = 3'd5;
	localparam logic [2:0] ST_WR    = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]   state_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] px_q;
	logic [YW-1:0] py_q;
	logic [3:0]    k_q;
	logic          wait_q;
	logic          pass_q;
	logic          inside_q;

	logic [igp_pkg::SIZE_W-1:0]   gw_q, gh_q;
	logic [igp_pkg::WEIGHT_W-1:0] decay_q, mom_q;
	logic [igp_pkg::WEIGHT_W-1:0] decay, mom;
	logic [XW-1:0] wlim;
	logic [YW-1:0] hlim;

	logic          rsp_valid_q;
	logic signed [DW-1:0] rsp_value_q;
	logic          rsp_done_q;
	logic          rsp_load;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	igp_pkg::nb_tag_t tag_s1;
	igp_pkg::cu_ctl_t cu_ctl;
	logic signed [DW-1:0] cu_result;

	logic          req_acc, rsp_free, req_inside;
	logic [1:0]    dx, dy;
	logic          nb_use;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [AW-1:0] req_addr, cell_addr, nb_addr;

	// Active size and weights after clamping to their legal ranges.
	always_comb begin
		if (gw_q == '0) begin
			wlim = '0;
		end else if (int'(gw_q) > MAX_WIDTH) begin
			wlim = XW'(MAX_WIDTH - 1);
		end else begin
			wlim = XW'(gw_q - 8'd1);
		end
		if (gh_q == '0) begin
			hlim = '0;
		end else if (int'(gh_q) > MAX_HEIGHT) begin
			hlim = YW'(MAX_HEIGHT - 1);
		end else begin
			hlim = YW'(gh_q - 8'd1);
		end
		decay = (decay_q > igp_pkg::ONE_Q16) ? igp_pkg::ONE_Q16 : decay_q;
		mom   = (mom_q > igp_pkg::ONE_Q16) ? igp_pkg::ONE_Q16 : mom_q;
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= 8'd128;
			gh_q    <= 8'd128;
			decay_q <= 17'd65536;
			mom_q   <= 17'd32768;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				igp_pkg::REG_GRID_WIDTH:  gw_q    <= cfg.data[igp_pkg::SIZE_W-1:0];
				igp_pkg::REG_GRID_HEIGHT: gh_q    <= cfg.data[igp_pkg::SIZE_W-1:0];
				igp_pkg::REG_DECAY:       decay_q <= cfg.data;
				igp_pkg::REG_MOMENTUM:    mom_q   <= cfg.data;
			endcase
		end
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load   = ((state_q == ST_RRES) || (state_q == ST_DONE)) && rsp_free;
	assign req_inside = (int'(req.cell_x) < MAX_WIDTH) && (int'(req.cell_y) < MAX_HEIGHT);
	assign req_addr   = AW'(AW'(XW'(req.cell_x)) * AW'(MAX_HEIGHT)) + AW'(YW'(req.cell_y));
	assign cell_addr  = AW'(AW'(px_q) * AW'(MAX_HEIGHT)) + AW'(py_q);

	// Neighbor k of the cell: offsets 0, 1, 2 stand for -1, 0, +1; k = 4 is the cell.
	always_comb begin
		unique case (k_q)
			4'd0: begin dx = 2'd0; dy = 2'd0; end
			4'd1: begin dx = 2'd0; dy = 2'd1; end
			4'd2: begin dx = 2'd0; dy = 2'd2; end
			4'd3: begin dx = 2'd1; dy = 2'd0; end
			4'd5: begin dx = 2'd1; dy = 2'd2; end
			4'd6: begin dx = 2'd2; dy = 2'd0; end
			4'd7: begin dx = 2'd2; dy = 2'd1; end
			4'd8: begin dx = 2'd2; dy = 2'd2; end
			default: begin dx = 2'd1; dy = 2'd1; end
		endcase
		nb_use = (k_q != 4'd4)
			&& !(px_q == '0 && dx == 2'd0) && !(px_q == wlim && dx == 2'd2)
			&& !(py_q == '0 && dy == 2'd0) && !(py_q == hlim && dy == 2'd2);
		nx = (dx == 2'd0) ? px_q - 1'b1 : (dx == 2'd2) ? px_q + 1'b1 : px_q;
		ny = (dy == 2'd0) ? py_q - 1'b1 : (dy == 2'd2) ? py_q + 1'b1 : py_q;
		nb_addr = AW'(AW'(nx) * AW'(MAX_HEIGHT)) + AW'(ny);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr;
		ram_wdata = cu_result;
		ram_re    = 1'b0;
		ram_raddr = req_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_we    = req_acc && req.cmd == igp_pkg::CMD_WRITE && req_inside;
				ram_waddr = req_addr;
				ram_wdata = req.cell_value;
				ram_re    = req_acc && req.cmd == igp_pkg::CMD_READ;
			end
			ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = nb_use ? nb_addr : cell_addr;
			end
			ST_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cu_ctl.start = (state_q == ST_RD) && (k_q == 4'd0);
	assign cu_ctl.blend = (state_q == ST_BL);

	igp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_grid (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	igp_cell_unit u_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cu_ctl),
		.tag_s1 (tag_s1),
		.rdata  (ram_rdata),
		.decay  (decay),
		.mom    (mom),
		.result (cu_result)
	);

	// Sequencer: forward sweep x outer / y inner ascending, then backward descending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			px_q        <= '0;
			py_q        <= '0;
			k_q         <= '0;
			wait_q      <= 1'b0;
			pass_q      <= 1'b0;
			inside_q    <= 1'b0;
			tag_s1      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_value_q <= '0;
			rsp_done_q  <= 1'b0;
		end else begin
			tag_s1 <= '{valid: state_q == ST_RD, use_nb: nb_use, center: k_q == 4'd4};
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						inside_q <= req_inside;
						if (req.cmd == igp_pkg::CMD_READ) begin
							state_q <= ST_RRES;
						end else if (req.cmd == igp_pkg::CMD_PROPAGATE) begin
							state_q <= ST_RD;
							px_q    <= '0;
							py_q    <= '0;
							k_q     <= '0;
							pass_q  <= 1'b0;
						end
					end
				end
				ST_RRES: begin
					if (rsp_free) begin
						rsp_value_q <= inside_q ? signed'(ram_rdata) : '0;
						rsp_done_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_RD: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) begin
						state_q <= ST_WAIT;
						wait_q  <= 1'b0;
					end
				end
				ST_WAIT: begin
					wait_q <= 1'b1;
					if (wait_q) begin
						state_q <= ST_BL;
					end
				end
				ST_BL: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					k_q     <= '0;
					state_q <= ST_RD;
					if (!pass_q) begin
						if (py_q != hlim) begin
							py_q <= py_q + 1'b1;
						end else if (px_q != wlim) begin
							py_q <= '0;
							px_q <= px_q + 1'b1;
						end else begin
							pass_q <= 1'b1;
						end
					end else begin
						if (py_q != '0) begin
							py_q <= py_q - 1'b1;
						end else if (px_q != '0) begin
							py_q <= hlim;
							px_q <= px_q - 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_value_q <= '0;
						rsp_done_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.sweep_done = rsp_done_q;

	// A propagate completion always carries a zero value.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.sweep_done |-> rsp.read_value == '0)
		else $error("sweep result with nonzero value");

	// Grid writes during a sweep happen only after the blend cycle.
	a_wr_after_blend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> $past(state_q) == ST_BL)
		else $error("sweep write without blend");

	// A neighbor read never coincides with a write to the grid.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> !ram_we)
		else $error("grid write during neighbor reads");

	// A response is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_value_q))
		else $error("pending response overwritten");

endmodule
